>>> src/qmeu_pkg.sv
// Package with shared types, constants and operation codes of the queue machine execute unit.
package qmeu_pkg;

  localparam int QueueDepth = 4096;
  localparam int QAW = $clog2(QueueDepth);
  localparam int ProgramDepth = 4096;
  localparam int PAW = $clog2(ProgramDepth);
  localparam int NumRegs = 26;

  localparam logic [4:0] OP_PUSH_IMM = 5'd0;
  localparam logic [4:0] OP_ADD      = 5'd1;
  localparam logic [4:0] OP_SUB      = 5'd2;
  localparam logic [4:0] OP_MUL      = 5'd3;
  localparam logic [4:0] OP_DIV      = 5'd4;
  localparam logic [4:0] OP_MOD      = 5'd5;
  localparam logic [4:0] OP_POP_REG  = 5'd6;
  localparam logic [4:0] OP_PUSH_REG = 5'd7;
  localparam logic [4:0] OP_PNUM_Q   = 5'd8;
  localparam logic [4:0] OP_PNUM_R   = 5'd9;
  localparam logic [4:0] OP_PCHR_Q   = 5'd10;
  localparam logic [4:0] OP_PCHR_R   = 5'd11;
  localparam logic [4:0] OP_JMP      = 5'd12;
  localparam logic [4:0] OP_JZ       = 5'd13;
  localparam logic [4:0] OP_JEQ      = 5'd14;
  localparam logic [4:0] OP_JGT      = 5'd15;
  localparam logic [4:0] OP_QUIT     = 5'd16;

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_NUM  = 2'd1;
  localparam logic [1:0] PK_CHR  = 2'd2;

  typedef struct packed {
    logic [4:0]  operation;
    logic [4:0]  first_reg;
    logic [4:0]  second_reg;
    logic [15:0] immediate;
    logic [11:0] target;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  print_kind;
    logic [15:0] print_value;
    logic [11:0] next_index;
    logic        halted;
    logic        queue_error;
  } out_item_t;

endpackage

>>> src/qmeu_if.sv
// Valid/ready channel interfaces for requests and results.
interface qmeu_in_if (input logic clk);
  logic                valid;
  logic                ready;
  qmeu_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qmeu_out_if (input logic clk);
  logic                valid;
  logic                ready;
  qmeu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/qmeu_ram.sv
// Generic single-port RAM with registered read.
module qmeu_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Read-first: a write returns the old contents on rdata; registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> src/queue_machine_execute_unit.sv
// Top level of the queue machine execute unit.
// Usage: one decoded instruction arrives as a request on in_ch; exactly one
// result leaves on out_ch, carrying the print kind and value, the next
// instruction index, the halt flag and a queue error flag.
// Steps: add, sub and mul pop two operands, compute in the arithmetic unit
// and push; divide and modulo use the bit-serial 16-step divider instead;
// push and single pops make one queue access; jumps, quit, print-from-register
// and unused codes touch no queue. The queue memory port (one access per
// cycle) sets the pop and push steps. One request is worked at a time.
// The result sits in an output register; a new request can be taken in the
// cycle after that result has been taken, so a stalled receiver holds the
// block.
// Reset clears the registers, queue pointers, program counter and the halt
// flag at once; the queue memory needs no clearing since the count guards
// every read. After quit, every request returns halted with the held index.
module queue_machine_execute_unit (
  input logic        clk,
  input logic        rst_n,
  qmeu_in_if.sink    in_ch,
  qmeu_out_if.source out_ch
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POP1  = 4'd1;
  localparam logic [3:0] S_WAIT1 = 4'd2;
  localparam logic [3:0] S_POP2  = 4'd3;
  localparam logic [3:0] S_WAIT2 = 4'd4;
  localparam logic [3:0] S_ALU   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]  state_r, state_nxt;
  qmeu_pkg::in_item_t req_r;
  logic [qmeu_pkg::QAW-1:0] head_r, tail_r;
  logic [qmeu_pkg::QAW:0]   count_r;
  logic [15:0] regs_r [qmeu_pkg::NumRegs];
  logic [qmeu_pkg::PAW-1:0] pc_r;
  logic        halt_r;
  logic        err_r;
  logic [15:0] l_r, r_r, res_r;
  logic [16:0] rem_r;
  logic [4:0]  cnt_r;
  logic        pop_ok_r;
  qmeu_pkg::out_item_t out_r;
  logic        out_valid_r;

  logic        ram_we;
  logic [qmeu_pkg::QAW-1:0] ram_addr;
  logic [15:0] ram_wdata, ram_rdata;

  logic [15:0] ra_val, rb_val;
  logic        two_op, pops_one;
  logic        q_empty, q_full;
  logic [qmeu_pkg::QAW-1:0] head_inc, tail_inc;
  logic [16:0] div_trial;
  logic [qmeu_pkg::PAW-1:0] pc_inc, tgt;

  qmeu_ram #(.Width(16), .Depth(qmeu_pkg::QueueDepth)) u_qram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Register reads; indexes beyond the file read as zero.
  assign ra_val = (req_r.first_reg < 5'(qmeu_pkg::NumRegs)) ? regs_r[req_r.first_reg] : 16'd0;
  assign rb_val = (req_r.second_reg < 5'(qmeu_pkg::NumRegs)) ? regs_r[req_r.second_reg] : 16'd0;

  assign two_op = (req_r.operation >= qmeu_pkg::OP_ADD) && (req_r.operation <= qmeu_pkg::OP_MOD);
  assign pops_one = (req_r.operation == qmeu_pkg::OP_POP_REG) ||
                    (req_r.operation == qmeu_pkg::OP_PNUM_Q) ||
                    (req_r.operation == qmeu_pkg::OP_PCHR_Q);
  assign q_empty = (count_r == '0);
  assign q_full = (count_r == (qmeu_pkg::QAW+1)'(qmeu_pkg::QueueDepth));
  assign head_inc = (head_r == qmeu_pkg::QAW'(qmeu_pkg::QueueDepth - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == qmeu_pkg::QAW'(qmeu_pkg::QueueDepth - 1)) ? '0 : tail_r + 1'b1;
  assign pc_inc = (pc_r == qmeu_pkg::PAW'(qmeu_pkg::ProgramDepth - 1)) ? '0 : pc_r + 1'b1;
  // The program depth is a power of two, so the target wraps by keeping its low bits.
  assign tgt = qmeu_pkg::PAW'(req_r.target);
  assign div_trial = {rem_r[15:0], l_r[15]} - {1'b0, r_r};

  // Memory port: push writes at the tail, pops read at the head.
  always_comb begin
    ram_we = (state_r == S_PUSH) && !q_full;
    ram_addr = (state_r == S_PUSH) ? tail_r : head_r;
    ram_wdata = res_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_POP1;
        end
      end
      S_POP1: begin
        if (halt_r) begin
          state_nxt = S_DONE;
        end else if (two_op || pops_one) begin
          state_nxt = S_WAIT1;
        end else if (req_r.operation == qmeu_pkg::OP_PUSH_IMM ||
                     req_r.operation == qmeu_pkg::OP_PUSH_REG) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAIT1: state_nxt = two_op ? S_POP2 : S_DONE;
      S_POP2:  state_nxt = S_WAIT2;
      S_WAIT2: state_nxt = (req_r.operation == qmeu_pkg::OP_DIV ||
                            req_r.operation == qmeu_pkg::OP_MOD) ? S_DIV : S_ALU;
      S_ALU:   state_nxt = S_PUSH;
      S_DIV:   state_nxt = (cnt_r == 5'd15) ? S_PUSH : S_DIV;
      S_PUSH:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
      pc_r <= '0;
      halt_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < qmeu_pkg::NumRegs; i++) begin
        regs_r[i] <= 16'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // Pop: advance head when the queue holds an entry.
      if ((state_r == S_POP1 && !halt_r && (two_op || pops_one)) || state_r == S_POP2) begin
        if (!q_empty) begin
          head_r <= head_inc;
          count_r <= count_r - 1'b1;
        end
      end
      if (state_r == S_PUSH && !q_full) begin
        tail_r <= tail_inc;
        count_r <= count_r + 1'b1;
      end
      if (state_r == S_WAIT1 && req_r.operation == qmeu_pkg::OP_POP_REG &&
          req_r.first_reg < 5'(qmeu_pkg::NumRegs)) begin
        regs_r[req_r.first_reg] <= pop_ok_r ? ram_rdata : 16'd0;
      end
      if (state_r == S_DONE) begin
        out_valid_r <= 1'b1;
        if (!halt_r) begin
          if (req_r.operation == qmeu_pkg::OP_QUIT) begin
            halt_r <= 1'b1;
          end else if ((req_r.operation == qmeu_pkg::OP_JMP) ||
                       (req_r.operation == qmeu_pkg::OP_JZ && ra_val == 16'd0) ||
                       (req_r.operation == qmeu_pkg::OP_JEQ && ra_val == rb_val) ||
                       (req_r.operation == qmeu_pkg::OP_JGT && ra_val > rb_val)) begin
            pc_r <= tgt;
          end else begin
            pc_r <= pc_inc;
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      req_r <= in_ch.data;
      err_r <= 1'b0;
    end
    if (state_r == S_POP1) begin
      pop_ok_r <= !q_empty;
      if ((two_op || pops_one) && q_empty && !halt_r) begin
        err_r <= 1'b1;
      end
      if (req_r.operation == qmeu_pkg::OP_PUSH_IMM) begin
        res_r <= req_r.immediate;
      end else begin
        res_r <= ra_val;
      end
    end
    if (state_r == S_WAIT1) begin
      l_r <= pop_ok_r ? ram_rdata : 16'd0;
    end
    if (state_r == S_POP2) begin
      pop_ok_r <= !q_empty;
      if (q_empty) begin
        err_r <= 1'b1;
      end
    end
    if (state_r == S_WAIT2) begin
      r_r <= pop_ok_r ? ram_rdata : 16'd0;
      rem_r <= '0;
      cnt_r <= '0;
    end
    // Shared arithmetic unit: add, subtract, multiply.
    if (state_r == S_ALU) begin
      case (req_r.operation)
        qmeu_pkg::OP_ADD: res_r <= l_r + r_r;
        qmeu_pkg::OP_SUB: res_r <= l_r - r_r;
        default:          res_r <= 16'(l_r * r_r);
      endcase
    end
    // Restoring division, one quotient bit a cycle; quotient shifts into l_r.
    if (state_r == S_DIV) begin
      cnt_r <= cnt_r + 1'b1;
      if (!div_trial[16]) begin
        rem_r <= {1'b0, div_trial[15:0]};
        l_r <= {l_r[14:0], 1'b1};
      end else begin
        rem_r <= {1'b0, rem_r[14:0], l_r[15]};
        l_r <= {l_r[14:0], 1'b0};
      end
      if (cnt_r == 5'd15) begin
        if (r_r == 16'd0) begin
          res_r <= 16'd0;
        end else if (req_r.operation == qmeu_pkg::OP_DIV) begin
          res_r <= {l_r[14:0], !div_trial[16]};
        end else begin
          res_r <= div_trial[16] ? {rem_r[14:0], l_r[15]} : div_trial[15:0];
        end
      end
    end
    if (state_r == S_PUSH && q_full) begin
      err_r <= 1'b1;
    end
    // Result assembly.
    if (state_r == S_DONE) begin
      out_r.print_kind <= qmeu_pkg::PK_NONE;
      out_r.print_value <= 16'd0;
      out_r.queue_error <= halt_r ? 1'b0 : err_r;
      out_r.halted <= halt_r || (req_r.operation == qmeu_pkg::OP_QUIT);
      out_r.next_index <= 12'(pc_r);
      if (!halt_r) begin
        if (req_r.operation == qmeu_pkg::OP_JMP ||
            (req_r.operation == qmeu_pkg::OP_JZ && ra_val == 16'd0) ||
            (req_r.operation == qmeu_pkg::OP_JEQ && ra_val == rb_val) ||
            (req_r.operation == qmeu_pkg::OP_JGT && ra_val > rb_val)) begin
          out_r.next_index <= 12'(tgt);
        end else if (req_r.operation != qmeu_pkg::OP_QUIT) begin
          out_r.next_index <= 12'(pc_inc);
        end
        case (req_r.operation)
          qmeu_pkg::OP_PNUM_Q: begin
            out_r.print_kind <= qmeu_pkg::PK_NUM;
            out_r.print_value <= l_r;
          end
          qmeu_pkg::OP_PNUM_R: begin
            out_r.print_kind <= qmeu_pkg::PK_NUM;
            out_r.print_value <= ra_val;
          end
          qmeu_pkg::OP_PCHR_Q: begin
            out_r.print_kind <= qmeu_pkg::PK_CHR;
            out_r.print_value <= {8'd0, l_r[7:0]};
          end
          qmeu_pkg::OP_PCHR_R: begin
            out_r.print_kind <= qmeu_pkg::PK_CHR;
            out_r.print_value <= {8'd0, ra_val[7:0]};
          end
          default: ;
        endcase
      end
    end
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (qmeu_pkg::QAW+1)'(qmeu_pkg::QueueDepth))
    else $error("queue count beyond depth");
  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ch.ready)
    else $error("request taken while result pending");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared");
  a_halt_no_pc: assert property (@(posedge clk) disable iff (!rst_n)
    $past(halt_r) && halt_r |-> $stable(pc_r))
    else $error("program counter moved while halted");

endmodule

>>> tb/qmeu_checker.sv
// Checker for the queue machine execute unit: predicts every result and compares it.
`timescale 1ns / 100ps

module qmeu_checker (
  input  logic       clk,
  input  logic       rst_n,
  qmeu_in_if         in_ch,
  qmeu_out_if        out_ch,
  output int         fail_count,
  output int         pending
);

  // Machine state as the checker sees it.
  logic [15:0] ring [$];
  logic [15:0] regs [qmeu_pkg::NumRegs];
  logic [11:0] pc;
  logic        stopped;
  logic        flag_err;
  qmeu_pkg::out_item_t awaited [$];

  function automatic logic [15:0] ring_pop();
    if (ring.size() == 0) begin
      flag_err = 1'b1;
      return 16'd0;
    end
    return ring.pop_front();
  endfunction

  function automatic void ring_push(logic [15:0] v);
    if (ring.size() >= qmeu_pkg::QueueDepth) flag_err = 1'b1;
    else ring.push_back(v);
  endfunction

  function automatic logic [15:0] reg_get(logic [4:0] idx);
    return (idx < qmeu_pkg::NumRegs) ? regs[idx] : 16'd0;
  endfunction

  // Executes one instruction on the local machine state and returns its result.
  function automatic qmeu_pkg::out_item_t execute_instr(qmeu_pkg::in_item_t req);
    qmeu_pkg::out_item_t res;
    logic [15:0] lhs, rhs, val;
    logic [11:0] nxt;
    res = '0;
    flag_err = 1'b0;
    nxt = pc + 12'd1;
    if (stopped) begin
      nxt = pc;
    end else begin
      case (req.operation)
        qmeu_pkg::OP_PUSH_IMM: ring_push(req.immediate);
        qmeu_pkg::OP_ADD, qmeu_pkg::OP_SUB, qmeu_pkg::OP_MUL,
        qmeu_pkg::OP_DIV, qmeu_pkg::OP_MOD: begin
          lhs = ring_pop();
          rhs = ring_pop();
          case (req.operation)
            qmeu_pkg::OP_ADD: val = lhs + rhs;
            qmeu_pkg::OP_SUB: val = lhs - rhs;
            qmeu_pkg::OP_MUL: val = lhs * rhs;
            qmeu_pkg::OP_DIV: val = (rhs == 0) ? 16'd0 : lhs / rhs;
            default: val = (rhs == 0) ? 16'd0 : lhs % rhs;
          endcase
          ring_push(val);
        end
        qmeu_pkg::OP_POP_REG: begin
          val = ring_pop();
          if (req.first_reg < qmeu_pkg::NumRegs) regs[req.first_reg] = val;
        end
        qmeu_pkg::OP_PUSH_REG: ring_push(reg_get(req.first_reg));
        qmeu_pkg::OP_PNUM_Q: begin
          res.print_kind = qmeu_pkg::PK_NUM;
          res.print_value = ring_pop();
        end
        qmeu_pkg::OP_PNUM_R: begin
          res.print_kind = qmeu_pkg::PK_NUM;
          res.print_value = reg_get(req.first_reg);
        end
        qmeu_pkg::OP_PCHR_Q: begin
          res.print_kind = qmeu_pkg::PK_CHR;
          res.print_value = ring_pop() & 16'h00FF;
        end
        qmeu_pkg::OP_PCHR_R: begin
          res.print_kind = qmeu_pkg::PK_CHR;
          res.print_value = reg_get(req.first_reg) & 16'h00FF;
        end
        qmeu_pkg::OP_JMP: nxt = req.target;
        qmeu_pkg::OP_JZ: if (reg_get(req.first_reg) == 0) nxt = req.target;
        qmeu_pkg::OP_JEQ:
          if (reg_get(req.first_reg) == reg_get(req.second_reg)) nxt = req.target;
        qmeu_pkg::OP_JGT:
          if (reg_get(req.first_reg) > reg_get(req.second_reg)) nxt = req.target;
        qmeu_pkg::OP_QUIT: begin
          stopped = 1'b1;
          nxt = pc;
        end
        default: ;
      endcase
      pc = nxt;
    end
    res.next_index = nxt;
    res.halted = stopped;
    res.queue_error = flag_err;
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk) begin
    qmeu_pkg::out_item_t want, got;
    if (!rst_n) begin
      ring.delete();
      awaited.delete();
      foreach (regs[i]) regs[i] = 16'd0;
      pc = 12'd0;
      stopped = 1'b0;
      fail_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (awaited.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = awaited.pop_front();
          check_field("print_kind", want.print_kind, got.print_kind);
          check_field("print_value", want.print_value, got.print_value);
          check_field("next_index", want.next_index, got.next_index);
          check_field("halted", want.halted, got.halted);
          check_field("queue_error", want.queue_error, got.queue_error);
        end
      end
      if (in_ch.valid && in_ch.ready) awaited.push_back(execute_instr(in_ch.data));
    end
    pending = awaited.size();
  end

endmodule

>>> tb/tb_top.sv
// Testbench top: clock, reset, request stimulus, result flow control and verdict.
`timescale 1ns / 100ps

module tb_top;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   calm;
  bit   stall_req;
  int   quiet_cycles = 0;

  qmeu_in_if  in_ch (clk);
  qmeu_out_if out_ch (clk);

  queue_machine_execute_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  qmeu_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random stall bursts, plus one long hold-off on demand.
  initial begin
    int idle_left;
    bit stall_taken;
    idle_left = 0;
    stall_taken = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        idle_left = 400;
      end
      if (idle_left > 0) begin
        out_ch.ready = 1'b0;
        idle_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        idle_left = $urandom_range(0, 16);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 5000) begin
      $display("FAIL queue_machine_execute_unit");
      $finish;
    end
  end

  // Offers one request and holds it until accepted; may idle afterwards.
  task automatic send_req(qmeu_pkg::in_item_t req);
    in_ch.data = req;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  function automatic qmeu_pkg::in_item_t make_req(logic [4:0] op, logic [4:0] ra,
                                                  logic [4:0] rb, logic [15:0] imm,
                                                  logic [11:0] tgt);
    qmeu_pkg::in_item_t r;
    r.operation = op;
    r.first_reg = ra;
    r.second_reg = rb;
    r.immediate = imm;
    r.target = tgt;
    return r;
  endfunction

  // Random request, weighted so the queue usually holds operands.
  function automatic qmeu_pkg::in_item_t random_req();
    qmeu_pkg::in_item_t r;
    int pick;
    r.first_reg = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                              : 5'($urandom_range(0, 25));
    r.second_reg = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                               : 5'($urandom_range(0, 25));
    case ($urandom_range(0, 3))
      0: r.immediate = 16'($urandom_range(0, 9));
      1: r.immediate = 16'hFFFF - 16'($urandom_range(0, 3));
      default: r.immediate = 16'($urandom);
    endcase
    r.target = 12'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 32) r.operation = qmeu_pkg::OP_PUSH_IMM;
    else if (pick < 42) r.operation = qmeu_pkg::OP_PUSH_REG;
    else if (pick < 64) r.operation = 5'($urandom_range(qmeu_pkg::OP_ADD, qmeu_pkg::OP_MOD));
    else if (pick < 72) r.operation = qmeu_pkg::OP_POP_REG;
    else if (pick < 84)
      r.operation = 5'($urandom_range(qmeu_pkg::OP_PNUM_Q, qmeu_pkg::OP_PCHR_R));
    else if (pick < 97)
      r.operation = 5'($urandom_range(qmeu_pkg::OP_JMP, qmeu_pkg::OP_JGT));
    else r.operation = 5'($urandom_range(qmeu_pkg::OP_QUIT + 1, 31));
    return r;
  endfunction

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    stall_req = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: underflows on an empty queue, wraps, zero divisors, bad indexes.
    send_req(make_req(qmeu_pkg::OP_PNUM_Q, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_ADD, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_POP_REG, 5'd1, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PUSH_IMM, 5'd0, 5'd0, 16'hFFFF, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PUSH_IMM, 5'd0, 5'd0, 16'hFFFF, 12'd0));
    send_req(make_req(qmeu_pkg::OP_MUL, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PUSH_IMM, 5'd0, 5'd0, 16'hFFFF, 12'd0));
    send_req(make_req(qmeu_pkg::OP_ADD, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PUSH_IMM, 5'd0, 5'd0, 16'd5, 12'd0));
    send_req(make_req(qmeu_pkg::OP_SUB, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PUSH_IMM, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_DIV, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PUSH_IMM, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_MOD, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PUSH_IMM, 5'd0, 5'd0, 16'd300, 12'd0));
    send_req(make_req(qmeu_pkg::OP_POP_REG, 5'd25, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PUSH_REG, 5'd25, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PCHR_Q, 5'd0, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PNUM_R, 5'd25, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PCHR_R, 5'd25, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_POP_REG, 5'd31, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_PNUM_R, 5'd31, 5'd0, 16'd0, 12'd0));
    send_req(make_req(qmeu_pkg::OP_JMP, 5'd0, 5'd0, 16'd0, 12'hFFF));
    send_req(make_req(qmeu_pkg::OP_JZ, 5'd0, 5'd0, 16'd0, 12'h555));
    send_req(make_req(qmeu_pkg::OP_JEQ, 5'd25, 5'd25, 16'd0, 12'hAAA));
    send_req(make_req(qmeu_pkg::OP_JGT, 5'd25, 5'd0, 16'd0, 12'h001));
    send_req(make_req(5'd31, 5'd0, 5'd0, 16'd0, 12'd0));

    // Random part with one long result stall and one drain pause.
    for (int n = 0; n < 620; n++) begin
      if (n == 200) stall_req = 1'b1;
      if (n == 400) begin
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (n == 520) calm = 1'b1;
      send_req(random_req());
    end

    // Quit, then requests that must be ignored.
    send_req(make_req(qmeu_pkg::OP_QUIT, 5'd0, 5'd0, 16'd0, 12'd0));
    for (int n = 0; n < 4; n++) send_req(random_req());
    in_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS queue_machine_execute_unit");
    end else begin
      $display("FAIL queue_machine_execute_unit");
    end
    $finish;
  end

endmodule
